/* sv/rbd_pkg.sv */
// Package with the types, codes and constants of the region boundary pixel detector.
`default_nettype none

package rbd_pkg;

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;

  localparam int OP_W       = 2;
  localparam int COORD_W    = 8;
  localparam int DIM_W      = 9;
  localparam int THR_W      = 4;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [OP_W-1:0] OP_MARK     = 2'd0;
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd1;
  localparam logic [OP_W-1:0] OP_UNMARK   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MIN = 2'd2;

  localparam logic [DIM_W-1:0] ROWS_RESET     = 9'd256;
  localparam logic [DIM_W-1:0] COLS_RESET     = 9'd256;
  localparam logic [THR_W-1:0] EDGE_MIN_RESET = 4'd4;
  localparam logic [COUNT_W-1:0] ALL_EMPTY    = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic [COUNT_W-1:0] empty_neighbours;
    logic               is_edge;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows_in_use;
    logic [DIM_W-1:0] cols_in_use;
    logic [THR_W-1:0] edge_min_empty;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_HOLD,
    ST_MRD,
    ST_MWR
  } state_t;

endpackage

`default_nettype wire

/* sv/region_boundary_pixel_detect_top.sv */
// Top level of the region boundary pixel detector: configuration registers, sequencer, memory.
//
//   channel  direction  handshake            payload
//   in_      request    in_valid / in_ready  in_item_t (op, cell_row, cell_col)
//   out_     result     out_valid / out_ready out_item_t (row, col, count, edge flag)
//   cfg_     write      cfg_we               cfg_index, cfg_wdata
//
// A classify request passes through the accept cycle, up to three row reads on the single
// memory read port and a final cycle that adds the last row and loads the output register.
// Mark and unmark do the read-modify-write of one memory row after the accept cycle; an unused
// op is accepted and dropped. After reset a clearing pass writes MAX_ROWS rows, one per cycle, before the
// first request is accepted. A result waiting in the output register does not block the
// next request; a classify stalls at its end until the output register is free.
`default_nettype none

module region_boundary_pixel_detect_top
  import rbd_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RAW = $clog2(MAX_ROWS);

  cfg_t                cfg_r;
  logic                mem_wr_en, mem_rd_en;
  logic [RAW-1:0]      mem_wr_addr, mem_rd_addr;
  logic [MAX_COLS-1:0] mem_wr_data, mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows_in_use    <= ROWS_RESET;
      cfg_r.cols_in_use    <= COLS_RESET;
      cfg_r.edge_min_empty <= EDGE_MIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS:     cfg_r.rows_in_use    <= cfg_wdata[DIM_W-1:0];
        CFG_COLS:     cfg_r.cols_in_use    <= cfg_wdata[DIM_W-1:0];
        CFG_EDGE_MIN: cfg_r.edge_min_empty <= cfg_wdata[THR_W-1:0];
        default:      cfg_r                <= cfg_r;
      endcase
    end
  end

  rbd_ctrl #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  rbd_mem #(
    .DEPTH(MAX_ROWS),
    .WIDTH(MAX_COLS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

endmodule

`default_nettype wire

/* sv/rbd_mem.sv */
// Row-wide synchronous membership memory with one write port and one registered read port.
`default_nettype none

module rbd_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* sv/rbd_ctrl.sv */
// Sequencer that clears the memory, updates rows and scans the three rows around a cell.
`default_nettype none

module rbd_ctrl
  import rbd_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire cfg_t                        cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire in_item_t                    in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output out_item_t                        out_data,
  output logic                             mem_wr_en,
  output logic [$clog2(MAX_ROWS)-1:0]      mem_wr_addr,
  output logic [MAX_COLS-1:0]              mem_wr_data,
  output logic                             mem_rd_en,
  output logic [$clog2(MAX_ROWS)-1:0]      mem_rd_addr,
  input  wire logic [MAX_COLS-1:0]         mem_rd_data
);

  localparam int RAW = $clog2(MAX_ROWS);
  localparam int CAW = $clog2(MAX_COLS);
  localparam int RLW = ($clog2(MAX_ROWS + 1) > DIM_W) ? $clog2(MAX_ROWS + 1) : DIM_W;
  localparam int CLW = ($clog2(MAX_COLS + 1) > DIM_W) ? $clog2(MAX_COLS + 1) : DIM_W;
  localparam logic [RAW-1:0] CLR_LAST = RAW'(MAX_ROWS - 1);

  state_t              state_r, state_nxt;
  in_item_t            item_r;
  logic [1:0]          s_r;
  logic [COUNT_W-1:0]  count_r;
  logic [RAW-1:0]      clr_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [RLW-1:0]      nr, rows_ext, r_ext;
  logic [CLW-1:0]      nc, cols_ext, c_ext;
  logic [RLW-1:0]      row_k [3];
  logic [CLW-1:0]      col_k [3];
  logic [2:0]          rowv, colv;
  logic [1:0]          proc_idx;
  logic [1:0]          row_empty;
  logic [COUNT_W-1:0]  cnt_fin;
  logic [COUNT_W-1:0]  cnt_sel;
  logic                accept, load_out, out_free, cell_inside;
  logic [MAX_COLS-1:0] mod_row;

  assign rows_ext = RLW'(cfg.rows_in_use);
  assign cols_ext = CLW'(cfg.cols_in_use);
  assign r_ext    = RLW'(item_r.cell_row);
  assign c_ext    = CLW'(item_r.cell_col);

  always_comb begin
    if (rows_ext == '0) begin
      nr = RLW'(1);
    end else if (rows_ext > RLW'(MAX_ROWS)) begin
      nr = RLW'(MAX_ROWS);
    end else begin
      nr = rows_ext;
    end
    if (cols_ext == '0) begin
      nc = CLW'(1);
    end else if (cols_ext > CLW'(MAX_COLS)) begin
      nc = CLW'(MAX_COLS);
    end else begin
      nc = cols_ext;
    end
  end

  always_comb begin
    row_k[0] = r_ext - RLW'(1);
    row_k[1] = r_ext;
    row_k[2] = r_ext + RLW'(1);
    col_k[0] = c_ext - CLW'(1);
    col_k[1] = c_ext;
    col_k[2] = c_ext + CLW'(1);
    rowv[0]  = (r_ext != '0) && (row_k[0] < nr);
    rowv[1]  = row_k[1] < nr;
    rowv[2]  = row_k[2] < nr;
    colv[0]  = (c_ext != '0) && (col_k[0] < nc);
    colv[1]  = col_k[1] < nc;
    colv[2]  = col_k[2] < nc;
  end

  assign cell_inside = rowv[1] && colv[1];
  assign proc_idx    = s_r - 2'd1;

  always_comb begin
    row_empty = '0;
    for (int j = 0; j < 3; j++) begin
      if (!(proc_idx == 2'd1 && j == 1)) begin
        if (!(rowv[proc_idx] && colv[j] && mem_rd_data[col_k[j][CAW-1:0]])) begin
          row_empty = row_empty + 2'd1;
        end
      end
    end
  end

  assign cnt_fin = count_r + COUNT_W'(row_empty);

  always_comb begin
    mod_row = mem_rd_data;
    mod_row[col_k[1][CAW-1:0]] = (item_r.op == OP_MARK);
  end

  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          priority if (in_data.op == OP_CLASSIFY) begin
            state_nxt = ST_SCAN;
          end else if (in_data.op == OP_MARK || in_data.op == OP_UNMARK) begin
            state_nxt = ST_MRD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (s_r == 2'd3) state_nxt = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_MRD: state_nxt = ST_MWR;
      ST_MWR: state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = row_k[1][RAW-1:0];
    mem_wr_data = mod_row;
    mem_rd_en   = 1'b0;
    mem_rd_addr = row_k[1][RAW-1:0];
    load_out    = 1'b0;
    cnt_sel     = cnt_fin;
    unique case (state_r)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_r;
        mem_wr_data = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCAN: begin
        if (s_r != 2'd3) begin
          mem_rd_en   = rowv[s_r];
          mem_rd_addr = row_k[s_r][RAW-1:0];
        end else begin
          load_out = out_free;
        end
      end
      ST_HOLD: begin
        load_out = out_free;
        cnt_sel  = count_r;
      end
      ST_MRD: begin
        mem_rd_en = cell_inside;
      end
      ST_MWR: begin
        mem_wr_en = cell_inside;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      s_r         <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + RAW'(1);
      if (accept) begin
        s_r     <= '0;
        count_r <= '0;
      end else if (state_r == ST_SCAN) begin
        s_r <= s_r + 2'd1;
        if (s_r != 2'd0) count_r <= cnt_fin;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    if (load_out) begin
      out_data_r.out_row          <= item_r.cell_row;
      out_data_r.out_col          <= item_r.cell_col;
      out_data_r.empty_neighbours <= cnt_sel;
      out_data_r.is_edge          <= (cnt_sel >= cfg.edge_min_empty) && (cnt_sel < ALL_EMPTY);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (state_r == ST_CLEAR || state_r == ST_MWR))
    else $error("memory written outside clearing or row update");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(load_out && out_valid_r && !out_ready))
    else $error("pending result overwritten");

  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && state_nxt != ST_CLEAR) |-> clr_r == CLR_LAST)
    else $error("clearing pass ended early");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_HOLD) |-> count_r <= ALL_EMPTY)
    else $error("neighbour count out of range");

endmodule

`default_nettype wire

/* tb/sv/tb_region_boundary_pixel_detect_top.sv */
// Self-checking testbench of the region boundary pixel detector with its own membership-map predictor.
module tb_region_boundary_pixel_detect_top;
  import rbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PER_PHASE = 300;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  in_item_t pending_reqs[$];
  out_item_t expected_results[$];

  bit region_bits [DEF_MAX_ROWS][DEF_MAX_COLS];
  logic [DIM_W-1:0] rows_cfg = ROWS_RESET;
  logic [DIM_W-1:0] cols_cfg = COLS_RESET;
  logic [THR_W-1:0] thr_cfg = EDGE_MIN_RESET;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int holds_started = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int requests_accepted = 0;
  int results_checked = 0;
  int settings_used = 0;

  region_boundary_pixel_detect_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int eff_dim(logic [DIM_W-1:0] v, int max_dim);
    if (v == 0) return 1;
    if (int'(v) > max_dim) return max_dim;
    return int'(v);
  endfunction

  function automatic bit in_raster(int r, int c);
    if (r < 0 || c < 0) return 1'b0;
    return r < eff_dim(rows_cfg, DEF_MAX_ROWS) && c < eff_dim(cols_cfg, DEF_MAX_COLS);
  endfunction

  function automatic void predict_request(in_item_t req);
    int r;
    int c;
    int empties;
    out_item_t res;
    r = int'(req.cell_row);
    c = int'(req.cell_col);
    empties = 0;
    case (req.op)
      OP_MARK: begin
        if (in_raster(r, c)) region_bits[r][c] = 1'b1;
      end
      OP_UNMARK: begin
        if (in_raster(r, c)) region_bits[r][c] = 1'b0;
      end
      OP_CLASSIFY: begin
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              if (!in_raster(r + dr, c + dc) || !region_bits[r + dr][c + dc]) empties++;
            end
          end
        end
        res.out_row = req.cell_row;
        res.out_col = req.cell_col;
        res.empty_neighbours = empties[COUNT_W-1:0];
        res.is_edge = (empties >= int'(thr_cfg)) && (empties < int'(ALL_EMPTY));
        expected_results = {expected_results, res};
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    results_checked++;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result row %0d col %0d",
                                got.out_row, got.out_col));
    end else begin
      want = expected_results.pop_front();
      if (got.out_row !== want.out_row)
        report_mismatch($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
      if (got.out_col !== want.out_col)
        report_mismatch($sformatf("out_col %0d, want %0d", got.out_col, want.out_col));
      if (got.empty_neighbours !== want.empty_neighbours)
        report_mismatch($sformatf("empty_neighbours %0d, want %0d at cell %0d,%0d",
                                  got.empty_neighbours, want.empty_neighbours,
                                  want.out_row, want.out_col));
      if (got.is_edge !== want.is_edge)
        report_mismatch($sformatf("is_edge %0b, want %0b at cell %0d,%0d",
                                  got.is_edge, want.is_edge, want.out_row, want.out_col));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_data);
        requests_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_started < holds_asked) begin
      holds_started <= holds_started + 1;
      hold_left <= LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROWS: rows_cfg = val[DIM_W-1:0];
      CFG_COLS: cols_cfg = val[DIM_W-1:0];
      CFG_EDGE_MIN: thr_cfg = val[THR_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_req(logic [OP_W-1:0] op, int r, int c);
    in_item_t it;
    it.op = op;
    it.cell_row = r[COORD_W-1:0];
    it.cell_col = c[COORD_W-1:0];
    pending_reqs = {pending_reqs, it};
  endtask

  task automatic queue_directed();
    queue_req(OP_MARK, 0, 0);
    queue_req(OP_MARK, 0, 1);
    queue_req(OP_MARK, 1, 0);
    queue_req(OP_MARK, 1, 1);
    queue_req(OP_CLASSIFY, 0, 0);
    queue_req(OP_CLASSIFY, 255, 255);
    queue_req(OP_UNUSED, 5, 5);
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if (dr != 0 || dc != 0) queue_req(OP_MARK, 20 + dr, 20 + dc);
    queue_req(OP_CLASSIFY, 20, 20);
    queue_req(OP_UNMARK, 19, 19);
    queue_req(OP_CLASSIFY, 20, 20);
    queue_req(OP_MARK, 255, 255);
    queue_req(OP_MARK, 254, 254);
    queue_req(OP_CLASSIFY, 255, 254);
    queue_req(OP_UNUSED, 255, 255);
    queue_req(OP_CLASSIFY, 0, 255);
    queue_req(OP_UNMARK, 0, 0);
    queue_req(OP_CLASSIFY, 1, 1);
  endtask

  task automatic queue_random(int n);
    int er;
    int ec;
    int fr;
    int fc;
    int r;
    int c;
    int pick;
    logic [OP_W-1:0] op;
    er = eff_dim(rows_cfg, DEF_MAX_ROWS);
    ec = eff_dim(cols_cfg, DEF_MAX_COLS);
    fr = 0;
    fc = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        pick = $urandom_range(3);
        fr = (pick == 0) ? 0 : (pick == 1) ? er - 1 : $urandom_range(er - 1);
        pick = $urandom_range(3);
        fc = (pick == 0) ? 0 : (pick == 1) ? ec - 1 : $urandom_range(ec - 1);
      end
      if ($urandom_range(99) < 80) begin
        r = fr + $urandom_range(6) - 3;
        c = fc + $urandom_range(6) - 3;
      end else begin
        r = $urandom_range(255);
        c = $urandom_range(255);
      end
      pick = $urandom_range(99);
      if (pick < 40) op = OP_MARK;
      else if (pick < 78) op = OP_CLASSIFY;
      else if (pick < 95) op = OP_UNMARK;
      else op = OP_UNUSED;
      queue_req(op, r, c);
    end
  endtask

  task automatic run_phase(int rows, int cols, int thr, int mode, bit directed, bit long_hold);
    wait_idle();
    write_reg(CFG_ROWS, rows[CFG_DATA_W-1:0]);
    write_reg(CFG_COLS, cols[CFG_DATA_W-1:0]);
    write_reg(CFG_EDGE_MIN, thr[CFG_DATA_W-1:0]);
    settings_used++;
    send_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 46 : 0;
    recv_idle_pct = (mode == 0) ? 46 : (mode == 1) ? 10 : 0;
    @(negedge clk);
    if (directed) queue_directed();
    if (long_hold) holds_asked++;
    queue_random(RANDOM_PER_PHASE);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    run_phase(256, 256, 4, 0, 1'b1, 1'b1);
    run_phase(0, 511, 0, 0, 1'b0, 1'b0);
    run_phase(12, 9, 8, 1, 1'b0, 1'b0);
    run_phase(1, 1, 15, 1, 1'b0, 1'b0);
    run_phase(40, 33, 3, 2, 1'b0, 1'b0);
    run_phase(256, 256, 1, 2, 1'b0, 1'b0);
    wait_idle();
    repeat (20) @(posedge clk);
    $display("run covered %0d requests under %0d register settings, %0d results checked",
             requests_accepted, settings_used, results_checked);
    $display("including a %0d-cycle output stall with the input kept busy, %0d mismatches",
             LONG_HOLD_CYCLES, mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still expected", expected_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
sv/rbd_pkg.sv
sv/rbd_mem.sv
sv/rbd_ctrl.sv
sv/region_boundary_pixel_detect_top.sv
tb/sv/tb_region_boundary_pixel_detect_top.sv
